/* rtl/scf_pkg.sv */
// shared types, constants and lookup tables for the scancode to character fifo
package scf_pkg;

	localparam int FIFO_DEPTH_DEF = 256;

	localparam int CHAR_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int TAB_LEN  = 58;
	localparam int TAB_IDX_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ARROW_UP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_DOWN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_LEFT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_RIGHT = 2'd3;

	localparam logic [7:0] ARROW_UP_RST    = 8'd128;
	localparam logic [7:0] ARROW_DOWN_RST  = 8'd129;
	localparam logic [7:0] ARROW_LEFT_RST  = 8'd130;
	localparam logic [7:0] ARROW_RIGHT_RST = 8'd131;

	localparam logic [7:0] SC_PREFIX      = 8'hE0;
	localparam logic [7:0] SC_UP          = 8'h48;
	localparam logic [7:0] SC_DOWN        = 8'h50;
	localparam logic [7:0] SC_LEFT        = 8'h4B;
	localparam logic [7:0] SC_RIGHT       = 8'h4D;
	localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
	localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
	localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
	localparam logic [7:0] SC_CAPS        = 8'h3A;

	typedef logic [3:0][CHAR_W-1:0] arrow_codes_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	localparam logic [7:0] PLAIN_TAB [0:TAB_LEN-1] = '{
		8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
		8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e,
		8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a, 8'h00, 8'h20
	};

	localparam logic [7:0] UPPER_TAB [0:TAB_LEN-1] = '{
		8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a,
		8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
		8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e,
		8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a, 8'h00, 8'h20
	};

endpackage

/* rtl/scf_decoder.sv */
// set-1 scancode decoder with shift, caps and extended prefix flags
module scf_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [7:0]                   scan_byte,
	input  scf_pkg::arrow_codes_t        arrow_codes,
	output logic [scf_pkg::CHAR_W-1:0]   dec_char
);

	logic shift_q;
	logic caps_q;
	logic prefix_q;
	logic [scf_pkg::TAB_IDX_W-1:0] tab_idx;

	assign tab_idx = scan_byte[scf_pkg::TAB_IDX_W-1:0];

	always_comb begin
		dec_char = '0;
		if (scan_byte == scf_pkg::SC_PREFIX) begin
			dec_char = '0;
		end else if (prefix_q) begin
			if (scan_byte == scf_pkg::SC_UP)
				dec_char = arrow_codes[scf_pkg::REG_ARROW_UP];
			else if (scan_byte == scf_pkg::SC_DOWN)
				dec_char = arrow_codes[scf_pkg::REG_ARROW_DOWN];
			else if (scan_byte == scf_pkg::SC_LEFT)
				dec_char = arrow_codes[scf_pkg::REG_ARROW_LEFT];
			else if (scan_byte == scf_pkg::SC_RIGHT)
				dec_char = arrow_codes[scf_pkg::REG_ARROW_RIGHT];
		end else if (!scan_byte[7] && (scan_byte < 8'(scf_pkg::TAB_LEN))) begin
			dec_char = (shift_q || caps_q) ? scf_pkg::UPPER_TAB[tab_idx]
				: scf_pkg::PLAIN_TAB[tab_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			caps_q   <= 1'b0;
			prefix_q <= 1'b0;
		end else if (en) begin
			if (scan_byte == scf_pkg::SC_PREFIX) begin
				prefix_q <= 1'b1;
			end else if (prefix_q) begin
				prefix_q <= 1'b0;
			end else if (scan_byte == scf_pkg::SC_LSHIFT_MAKE
				|| scan_byte == scf_pkg::SC_RSHIFT_MAKE) begin
				shift_q <= 1'b1;
			end else if (scan_byte == scf_pkg::SC_LSHIFT_BRK
				|| scan_byte == scf_pkg::SC_RSHIFT_BRK) begin
				shift_q <= 1'b0;
			end else if (scan_byte == scf_pkg::SC_CAPS) begin
				caps_q <= ~caps_q;
			end
		end
	end

endmodule

/* rtl/scf_fifo.sv */
// character fifo on a synchronous memory with a registered read port
module scf_fifo #(
	parameter int DEPTH = scf_pkg::FIFO_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [scf_pkg::CHAR_W-1:0]  push_data,
	input  logic                        pop,
	output scf_pkg::fifo_stat_t         stat,
	output logic [scf_pkg::CHAR_W-1:0]  rd_data_q
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [scf_pkg::CHAR_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_nxt;
	logic [PTR_W-1:0] rd_ptr_nxt;
	logic             do_push;
	logic             do_pop;

	assign wr_ptr_nxt = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_ptr_nxt = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);

	assign stat.full  = (wr_ptr_nxt == rd_ptr_q);
	assign stat.empty = (wr_ptr_q == rd_ptr_q);

	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_nxt;
			if (do_pop)
				rd_ptr_q <= rd_ptr_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk) begin
		if (do_pop)
			rd_data_q <= mem[rd_ptr_q];
	end

endmodule

/* rtl/scancode_to_char_fifo_unit.sv */
// top level: keyboard scancode decoder feeding a character fifo
// Takes one item per clock cycle while in_ready is high, a scancode byte (mode 0) or a
// read request (mode 1), and returns exactly one result item per input item in the
// cycle after acceptance, from the registered memory read port. A new item enters in
// the same cycle that the previous result is taken, so with out_ready held high the
// block sustains one item per cycle. The fifo keeps FIFO_DEPTH-1 characters; a
// character decoded while it is full is dropped and flagged with char_dropped. Arrow
// codes must be written through the cfg port while the block is idle (not enforced).
module scancode_to_char_fifo_unit #(
	parameter int FIFO_DEPTH = scf_pkg::FIFO_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [7:0]                     scan_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     read_data,
	output logic                           read_valid,
	output logic                           char_dropped
);

	scf_pkg::arrow_codes_t       arrow_q;
	scf_pkg::fifo_stat_t         fifo_stat;
	logic [scf_pkg::CHAR_W-1:0]  dec_char;
	logic [scf_pkg::CHAR_W-1:0]  rd_data;
	logic                        in_acc;
	logic                        scan_en;
	logic                        pop_en;
	logic                        push_en;
	logic                        valid_s1;
	logic                        rvalid_s1;
	logic                        drop_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrow_q[scf_pkg::REG_ARROW_UP]    <= scf_pkg::ARROW_UP_RST;
			arrow_q[scf_pkg::REG_ARROW_DOWN]  <= scf_pkg::ARROW_DOWN_RST;
			arrow_q[scf_pkg::REG_ARROW_LEFT]  <= scf_pkg::ARROW_LEFT_RST;
			arrow_q[scf_pkg::REG_ARROW_RIGHT] <= scf_pkg::ARROW_RIGHT_RST;
		end else if (cfg_we) begin
			arrow_q[cfg_index] <= cfg_data;
		end
	end

	assign in_ready = !valid_s1 || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign scan_en  = in_acc && !mode;
	assign pop_en   = in_acc && mode;
	assign push_en  = scan_en && (dec_char != '0);

	scf_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (scan_en),
		.scan_byte   (scan_byte),
		.arrow_codes (arrow_q),
		.dec_char    (dec_char)
	);

	scf_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_en),
		.push_data (dec_char),
		.pop       (pop_en),
		.stat      (fifo_stat),
		.rd_data_q (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rvalid_s1 <= mode && !fifo_stat.empty;
			drop_s1   <= push_en && fifo_stat.full;
		end
	end

	assign out_valid    = valid_s1;
	assign read_valid   = rvalid_s1;
	assign char_dropped = drop_s1;
	assign read_data    = rvalid_s1 ? rd_data : '0;

endmodule

/* rtl/scf_checker.sv */
// port-level checks for the scancode to character fifo, bound to the top level
module scf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic       read_valid,
	input logic       char_dropped
);

	// an accepted item always shows its result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item without result");

	// input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// a read result never reports a drop
	a_read_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> !char_dropped)
		else $error("read and drop in one item");

	// no character without read_valid
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_data == 8'h00)
		else $error("read_data nonzero without read_valid");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("result changed while stalled");

endmodule

bind scancode_to_char_fifo_unit scf_checker u_scf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_data    (read_data),
	.read_valid   (read_valid),
	.char_dropped (char_dropped)
);

/* bench/scancode_to_char_fifo_checker.sv */
// checker for the scancode to character fifo: predicts every result and compares it field by field
module scancode_to_char_fifo_checker #(
	parameter int FIFO_DEPTH = scf_pkg::FIFO_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [scf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          mode,
	input  logic [7:0]                    scan_byte,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [7:0]                    read_data,
	input  logic                          read_valid,
	input  logic                          char_dropped,
	output int                            fail_count,
	output int                            outstanding,
	output int                            chars_popped,
	output int                            chars_dropped,
	output int                            empty_reads
);

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic       char_dropped;
	} reply_t;

	// us layout, index is the make code
	localparam logic [7:0] LOWER_KEYS [0:scf_pkg::TAB_LEN-1] = '{
		8'h00, 8'h00, "1", "2", "3", "4", "5", "6", "7", "8",
		"9", "0", "-", "=", 8'h08, 8'h00, "q", "w", "e", "r",
		"t", "y", "u", "i", "o", "p", "[", "]", 8'h0a, 8'h00,
		"a", "s", "d", "f", "g", "h", "j", "k", "l", ";",
		8'h27, 8'h60, 8'h00, 8'h5c, "z", "x", "c", "v", "b", "n",
		"m", ",", ".", "/", 8'h00, "*", 8'h00, " "
	};

	localparam logic [7:0] UPPER_KEYS [0:scf_pkg::TAB_LEN-1] = '{
		8'h00, 8'h00, "!", "@", "#", "$", "%", "^", "&", "*",
		"(", ")", "_", "+", 8'h08, 8'h00, "Q", "W", "E", "R",
		"T", "Y", "U", "I", "O", "P", "{", "}", 8'h0a, 8'h00,
		"A", "S", "D", "F", "G", "H", "J", "K", "L", ":",
		8'h22, "~", 8'h00, "|", "Z", "X", "C", "V", "B", "N",
		"M", "<", ">", "?", 8'h00, "*", 8'h00, " "
	};

	logic [7:0] arrow_code [0:3];
	logic       shift_on;
	logic       caps_on;
	logic       prefix_armed;
	logic [7:0] typed_chars [$];
	reply_t     awaited_replies [$];
	reply_t     got;
	reply_t     want;
	int         mismatches = 0;
	int         pop_total = 0;
	int         drop_total = 0;
	int         empty_total = 0;

	assign fail_count    = mismatches;
	assign chars_popped  = pop_total;
	assign chars_dropped = drop_total;
	assign empty_reads   = empty_total;

	function automatic logic store_char(input logic [7:0] ch);
		if (ch == 8'h00)
			return 1'b0;
		if (typed_chars.size() >= FIFO_DEPTH - 1) begin
			drop_total++;
			return 1'b1;
		end
		typed_chars.push_back(ch);
		return 1'b0;
	endfunction

	function automatic reply_t predict_reply(input logic is_read, input logic [7:0] code);
		reply_t r;
		logic [7:0] ch;
		r = '0;
		ch = 8'h00;
		if (is_read) begin
			if (typed_chars.size() > 0) begin
				r.read_data = typed_chars.pop_front();
				r.read_valid = 1'b1;
				pop_total++;
			end else begin
				empty_total++;
			end
		end else if (code == scf_pkg::SC_PREFIX) begin
			prefix_armed = 1'b1;
		end else if (prefix_armed) begin
			prefix_armed = 1'b0;
			case (code)
				scf_pkg::SC_UP:    ch = arrow_code[scf_pkg::REG_ARROW_UP];
				scf_pkg::SC_DOWN:  ch = arrow_code[scf_pkg::REG_ARROW_DOWN];
				scf_pkg::SC_LEFT:  ch = arrow_code[scf_pkg::REG_ARROW_LEFT];
				scf_pkg::SC_RIGHT: ch = arrow_code[scf_pkg::REG_ARROW_RIGHT];
				default:           ch = 8'h00;
			endcase
			r.char_dropped = store_char(ch);
		end else if (code == scf_pkg::SC_LSHIFT_MAKE || code == scf_pkg::SC_RSHIFT_MAKE) begin
			shift_on = 1'b1;
		end else if (code == scf_pkg::SC_LSHIFT_BRK || code == scf_pkg::SC_RSHIFT_BRK) begin
			shift_on = 1'b0;
		end else if (code == scf_pkg::SC_CAPS) begin
			caps_on = !caps_on;
		end else if (code < scf_pkg::TAB_LEN) begin
			ch = (shift_on || caps_on) ? UPPER_KEYS[code] : LOWER_KEYS[code];
			r.char_dropped = store_char(ch);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrow_code[scf_pkg::REG_ARROW_UP] = scf_pkg::ARROW_UP_RST;
			arrow_code[scf_pkg::REG_ARROW_DOWN] = scf_pkg::ARROW_DOWN_RST;
			arrow_code[scf_pkg::REG_ARROW_LEFT] = scf_pkg::ARROW_LEFT_RST;
			arrow_code[scf_pkg::REG_ARROW_RIGHT] = scf_pkg::ARROW_RIGHT_RST;
			shift_on = 1'b0;
			caps_on = 1'b0;
			prefix_armed = 1'b0;
			typed_chars.delete();
			awaited_replies.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				arrow_code[cfg_index] = cfg_data;
			if (out_valid && out_ready) begin
				got = {read_data, read_valid, char_dropped};
				if (awaited_replies.size() == 0) begin
					mismatches++;
					$error("result with no item awaiting it, read_data %0h", read_data);
				end else begin
					want = awaited_replies.pop_front();
					if (got.read_data !== want.read_data) begin
						mismatches++;
						$error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
					end
					if (got.read_valid !== want.read_valid) begin
						mismatches++;
						$error("read_valid: expected %0b, got %0b", want.read_valid,
							got.read_valid);
					end
					if (got.char_dropped !== want.char_dropped) begin
						mismatches++;
						$error("char_dropped: expected %0b, got %0b", want.char_dropped,
							got.char_dropped);
					end
				end
			end
			if (in_valid && in_ready)
				awaited_replies.push_back(predict_reply(mode, scan_byte));
			outstanding <= awaited_replies.size();
		end
	end

endmodule

/* bench/scancode_to_char_fifo_unit_test.sv */
// testbench top: drives keystrokes, reads and arrow-code writes into the fifo unit
module scancode_to_char_fifo_unit_test;

	localparam int DEPTH       = scf_pkg::FIFO_DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 400;

	typedef enum logic [1:0] {SEG_FILL, SEG_DRAIN, SEG_TYPING, SEG_NOISE} seg_kind_t;

	// directed opening, mode bit on top
	localparam logic [8:0] OPENING [0:24] = '{
		{1'b1, 8'h00},
		{1'b0, scf_pkg::SC_PREFIX}, {1'b0, scf_pkg::SC_UP},
		{1'b0, scf_pkg::SC_PREFIX}, {1'b0, scf_pkg::SC_DOWN},
		{1'b0, scf_pkg::SC_PREFIX}, {1'b0, scf_pkg::SC_LEFT},
		{1'b0, scf_pkg::SC_PREFIX}, {1'b0, scf_pkg::SC_RIGHT},
		{1'b0, scf_pkg::SC_PREFIX}, {1'b0, scf_pkg::SC_PREFIX},
		{1'b0, scf_pkg::SC_LSHIFT_MAKE},
		{1'b0, 8'h10},
		{1'b0, scf_pkg::SC_PREFIX}, {1'b0, 8'hC8},
		{1'b0, scf_pkg::SC_RSHIFT_MAKE}, {1'b0, 8'h02}, {1'b0, scf_pkg::SC_RSHIFT_BRK},
		{1'b0, scf_pkg::SC_CAPS}, {1'b0, 8'h1E}, {1'b0, scf_pkg::SC_CAPS},
		{1'b0, 8'h39}, {1'b0, 8'h00}, {1'b0, 8'h3B}, {1'b0, 8'hFF}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [scf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                    cfg_data = 8'h00;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          mode = 1'b0;
	logic [7:0]                    scan_byte = 8'h00;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [7:0]                    read_data;
	logic                          read_valid;
	logic                          char_dropped;

	int   fail_count;
	int   outstanding;
	int   chars_popped;
	int   chars_dropped;
	int   empty_reads;
	int   items_sent = 0;
	int   settings_used = 0;
	int   in_gap_max = 16;
	int   out_gap_max = 16;
	int   stall_cycles = 0;
	logic hold_request = 1'b0;

	always #2 clk = ~clk;

	scancode_to_char_fifo_unit #(.FIFO_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .scan_byte(scan_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .read_valid(read_valid), .char_dropped(char_dropped)
	);

	scancode_to_char_fifo_checker #(.FIFO_DEPTH(DEPTH)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .scan_byte(scan_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .read_valid(read_valid), .char_dropped(char_dropped),
		.fail_count(fail_count), .outstanding(outstanding),
		.chars_popped(chars_popped), .chars_dropped(chars_dropped),
		.empty_reads(empty_reads)
	);

	task automatic put_item(input logic is_read, input logic [7:0] code);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= is_read;
		scan_byte <= code;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic request_pop();
		put_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic shift_key();
		case ($urandom_range(0, 3))
			0: put_item(1'b0, scf_pkg::SC_LSHIFT_MAKE);
			1: put_item(1'b0, scf_pkg::SC_LSHIFT_BRK);
			2: put_item(1'b0, scf_pkg::SC_RSHIFT_MAKE);
			default: put_item(1'b0, scf_pkg::SC_RSHIFT_BRK);
		endcase
	endtask

	task automatic arrow_key();
		int roll;
		roll = $urandom_range(0, 99);
		put_item(1'b0, scf_pkg::SC_PREFIX);
		if (roll < 80) begin
			case ($urandom_range(0, 3))
				0: put_item(1'b0, scf_pkg::SC_UP);
				1: put_item(1'b0, scf_pkg::SC_DOWN);
				2: put_item(1'b0, scf_pkg::SC_LEFT);
				default: put_item(1'b0, scf_pkg::SC_RIGHT);
			endcase
		end else if (roll < 90) begin
			put_item(1'b0, scf_pkg::SC_PREFIX);
		end else begin
			put_item(1'b0, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_item(input seg_kind_t kind);
		int roll;
		roll = $urandom_range(0, 99);
		case (kind)
			SEG_FILL:
				if (roll < 90) put_item(1'b0, 8'($urandom_range(16, 25)));
				else if (roll < 96) shift_key();
				else arrow_key();
			SEG_DRAIN:
				if (roll < 93) request_pop();
				else put_item(1'b0, 8'($urandom_range(0, scf_pkg::TAB_LEN - 1)));
			SEG_TYPING:
				if (roll < 8) request_pop();
				else if (roll < 58) put_item(1'b0, 8'($urandom_range(0, scf_pkg::TAB_LEN - 1)));
				else if (roll < 70) shift_key();
				else if (roll < 75) put_item(1'b0, scf_pkg::SC_CAPS);
				else if (roll < 90) arrow_key();
				else put_item(1'b0, 8'($urandom_range(0, 255)));
			default:
				put_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic run_segment(input seg_kind_t kind, input int count);
		int start;
		start = items_sent;
		while (items_sent - start < count)
			random_item(kind);
	endtask

	task automatic set_arrows(input logic [7:0] up, input logic [7:0] down,
		input logic [7:0] left, input logic [7:0] right);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= scf_pkg::REG_ARROW_UP;
		cfg_data <= up;
		@(posedge clk);
		cfg_index <= scf_pkg::REG_ARROW_DOWN;
		cfg_data <= down;
		@(posedge clk);
		cfg_index <= scf_pkg::REG_ARROW_LEFT;
		cfg_data <= left;
		@(posedge clk);
		cfg_index <= scf_pkg::REG_ARROW_RIGHT;
		cfg_data <= right;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// receiver side
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			if (hold_request) begin
				hold = LONG_HOLD;
				hold_request <= 1'b0;
			end else begin
				hold = $urandom_range(0, out_gap_max);
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[i])
			put_item(OPENING[i][8], OPENING[i][7:0]);

		set_arrows(8'd1, 8'd255, 8'd0, 8'h5A);
		run_segment(SEG_FILL, 300);
		run_segment(SEG_DRAIN, 300);

		// long receiver hold with the sender pushing back to back
		set_arrows(8'd255, 8'd1, 8'd255, 8'd1);
		in_gap_max = 0;
		hold_request <= 1'b1;
		run_segment(SEG_TYPING, 100);

		set_arrows(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
		in_gap_max = 16;
		out_gap_max = 16;
		run_segment(SEG_NOISE, 60);
		in_gap_max = 0;
		out_gap_max = 0;
		run_segment(SEG_TYPING, 60);

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (5) @(posedge clk);

		$display("run: %0d items under %0d arrow-code settings, incl. a full fifo and a long stall",
			items_sent, settings_used + 1);
		$display("run: %0d characters read back, %0d dropped when full, %0d reads found it empty",
			chars_popped, chars_dropped, empty_reads);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
